>>> rtl/dual_motor_pulse_generator_defines.svh
// assertion macros shared by the pulse generator rtl
// expects clk and rst in the scope of every use
`ifndef DUAL_MOTOR_PULSE_GENERATOR_DEFINES_SVH
`define DUAL_MOTOR_PULSE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define DMPG_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dmpg check failed");
`define DMPG_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dmpg check failed");
`else
`define DMPG_CHECK(label, prop)
`define DMPG_CHECK_ALWAYS(label, prop)
`endif

`endif

>>> rtl/dmpg_pkg.sv
// shared types, constants and timing functions for the pulse generator
// no dependencies
package dmpg_pkg;

  localparam int TIME_WIDTH  = 10;
  localparam int CHANNELS    = 2;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_B        = (CHANNELS > 1) ? 1 : 0;
  localparam int CALC_W      = (TIME_WIDTH > 11) ? TIME_WIDTH : 11;
  localparam int DROP_W      = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX   = '1;
  localparam logic [TIME_WIDTH-1:0] RESET_TIME = TIME_WIDTH'(50);
  localparam logic [CALC_W-1:0]     FULL_LOW   = CALC_W'(1000);
  localparam logic [6:0]            DUTY_MAX   = 7'd100;

  localparam logic [1:0] DIR_BRAKE = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_REV   = 2'd2;

  localparam logic [1:0] BR_FWD   = 2'd1;
  localparam logic [1:0] BR_REV   = 2'd2;
  localparam logic [1:0] BR_BRAKE = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_DRIVE,
    OP_BRAKE,
    OP_IDLE
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CH_IDX_W-1:0]   chan;
    logic [1:0]            bridge;
    logic [TIME_WIDTH-1:0] hi;
    logic [TIME_WIDTH-1:0] lo;
  } op_t;

  function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [CALC_W-1:0] t);
    logic [TIME_WIDTH-1:0] r;
    if (t > CALC_W'(TIME_MAX)) begin
      r = TIME_MAX;
    end else begin
      r = t[TIME_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] low_time(input logic first,
                                                     input logic [6:0] duty);
    logic [6:0]        duty_s;
    logic [DROP_W-1:0] d;
    logic [DROP_W-1:0] drop;
    duty_s = (duty > DUTY_MAX) ? DUTY_MAX : duty;
    d      = DROP_W'(duty_s);
    if (first) begin
      drop = d * DROP_W'(9);
    end else begin
      drop = (d * DROP_W'(19)) >> 1;
    end
    return sat_time(FULL_LOW - CALC_W'(drop));
  endfunction

endpackage

>>> rtl/dmpg_front.sv
// front end: takes input transfers and classifies them into queue entries
// depends on dmpg_pkg
module dmpg_front import dmpg_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic                  motor,
  input  logic [1:0]            direction,
  input  logic [6:0]            duty,
  input  logic [9:0]            high_time,
  input  logic                  q_full,
  output logic                  push,
  output op_t                   op
);

  logic in_range;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign in_range = (32'(motor) < CHANNELS);

  always_comb begin
    op.chan   = CH_IDX_W'(motor);
    op.hi     = sat_time(CALC_W'(high_time));
    op.lo     = low_time(motor == 1'b0, duty);
    op.bridge = BR_BRAKE;
    op.kind   = OP_IDLE;
    if (!action) begin
      op.kind = OP_TICK;
    end else if (in_range) begin
      unique case (direction)
        DIR_BRAKE: begin
          op.kind   = OP_BRAKE;
          op.bridge = BR_BRAKE;
        end
        DIR_FWD: begin
          op.kind   = OP_DRIVE;
          op.bridge = BR_FWD;
        end
        DIR_REV: begin
          op.kind   = OP_DRIVE;
          op.bridge = BR_REV;
        end
        default: begin
          op.kind = OP_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/dmpg_fifo.sv
// short queue of classified operations between front and back
// depends on dmpg_pkg and the assertion macro header
`include "dual_motor_pulse_generator_defines.svh"
module dmpg_fifo import dmpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wr_op,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  rd_op
);

  op_t               store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_op = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DMPG_CHECK_ALWAYS(a_reset_empties, rst |=> count == '0)
  `DMPG_CHECK(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH))
  `DMPG_CHECK(a_no_pop_empty, pop |-> !empty)
  `DMPG_CHECK(a_no_push_full, push |-> !full)

endmodule

>>> rtl/dmpg_back.sv
// back end: per-channel pulse timers, shadow timing and output register
// depends on dmpg_pkg and the assertion macro header
`include "dual_motor_pulse_generator_defines.svh"
module dmpg_back import dmpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  op_t        op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       enable_a,
  output logic       enable_b,
  output logic       enable_any,
  output logic [1:0] bridge_a,
  output logic [1:0] bridge_b
);

  logic [TIME_WIDTH-1:0] countdown         [CHANNELS];
  logic [TIME_WIDTH-1:0] countdown_next    [CHANNELS];
  logic [TIME_WIDTH-1:0] active_hi         [CHANNELS];
  logic [TIME_WIDTH-1:0] active_hi_next    [CHANNELS];
  logic [TIME_WIDTH-1:0] active_lo         [CHANNELS];
  logic [TIME_WIDTH-1:0] active_lo_next    [CHANNELS];
  logic [TIME_WIDTH-1:0] shadow_hi         [CHANNELS];
  logic [TIME_WIDTH-1:0] shadow_hi_next    [CHANNELS];
  logic [TIME_WIDTH-1:0] shadow_lo         [CHANNELS];
  logic [TIME_WIDTH-1:0] shadow_lo_next    [CHANNELS];
  logic [1:0]            bridge_pins       [CHANNELS];
  logic [1:0]            bridge_pins_next  [CHANNELS];
  logic [CHANNELS-1:0]   next_level;
  logic [CHANNELS-1:0]   next_level_next;
  logic [CHANNELS-1:0]   pending;
  logic [CHANNELS-1:0]   pending_next;
  logic [CHANNELS-1:0]   stopped;
  logic [CHANNELS-1:0]   stopped_next;
  logic [CHANNELS-1:0]   enable_level;
  logic [CHANNELS-1:0]   enable_level_next;
  logic                  hit;

  assign pop = !q_empty && (!out_valid || out_ready);

  always_comb begin
    countdown_next    = countdown;
    active_hi_next    = active_hi;
    active_lo_next    = active_lo;
    shadow_hi_next    = shadow_hi;
    shadow_lo_next    = shadow_lo;
    bridge_pins_next  = bridge_pins;
    next_level_next   = next_level;
    pending_next      = pending;
    stopped_next      = stopped;
    enable_level_next = enable_level;
    hit               = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit = (op.chan == CH_IDX_W'(c));
      unique case (op.kind)
        OP_TICK: begin
          if (!stopped[c]) begin
            if (countdown[c] > TIME_WIDTH'(1)) begin
              countdown_next[c] = countdown[c] - 1'b1;
            end else begin
              enable_level_next[c] = next_level[c];
              countdown_next[c]    = next_level[c] ? active_hi[c] : active_lo[c];
              next_level_next[c]   = !next_level[c];
              if (pending[c]) begin
                pending_next[c]   = 1'b0;
                active_hi_next[c] = shadow_hi[c];
                active_lo_next[c] = shadow_lo[c];
              end
            end
          end
        end
        OP_DRIVE: begin
          if (hit) begin
            bridge_pins_next[c] = op.bridge;
            if (stopped[c]) begin
              active_hi_next[c] = op.hi;
              active_lo_next[c] = op.lo;
              countdown_next[c] = op.hi;
              stopped_next[c]   = 1'b0;
            end else begin
              pending_next[c]   = 1'b1;
              shadow_hi_next[c] = op.hi;
              shadow_lo_next[c] = op.lo;
            end
          end
        end
        OP_BRAKE: begin
          if (hit) begin
            bridge_pins_next[c]  = BR_BRAKE;
            stopped_next[c]      = 1'b1;
            enable_level_next[c] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        countdown[c]   <= '0;
        active_hi[c]   <= RESET_TIME;
        active_lo[c]   <= RESET_TIME;
        shadow_hi[c]   <= '0;
        shadow_lo[c]   <= '0;
        bridge_pins[c] <= BR_BRAKE;
      end
      next_level   <= '1;
      pending      <= '0;
      stopped      <= '1;
      enable_level <= '0;
    end else if (pop) begin
      countdown    <= countdown_next;
      active_hi    <= active_hi_next;
      active_lo    <= active_lo_next;
      shadow_hi    <= shadow_hi_next;
      shadow_lo    <= shadow_lo_next;
      bridge_pins  <= bridge_pins_next;
      next_level   <= next_level_next;
      pending      <= pending_next;
      stopped      <= stopped_next;
      enable_level <= enable_level_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      enable_a   <= enable_level_next[0];
      enable_b   <= (CHANNELS > 1) ? enable_level_next[CH_B] : 1'b0;
      enable_any <= |enable_level_next;
      bridge_a   <= bridge_pins_next[0];
      bridge_b   <= (CHANNELS > 1) ? bridge_pins_next[CH_B] : BR_BRAKE;
    end
  end

  `DMPG_CHECK(a_pop_gives_result, pop |=> out_valid)
  `DMPG_CHECK(a_stopped_enable_low, (stopped & enable_level) == '0)
  `DMPG_CHECK(a_hold_without_pop, !pop |=> $stable(enable_level) && $stable(stopped))

endmodule

>>> rtl/dual_motor_pulse_generator.sv
// dual channel motor pulse generator, top level
// an input is queued on transfer, and its result then goes into the output register
// throughput: one item per cycle unless out_ready stalls; set by the dmpg_back update
// a two-entry queue decouples input and output; an output register holds the result
// reset (rst, synchronous): queue emptied, both channels stopped, bridges braked
// depends on dmpg_pkg, dmpg_front, dmpg_fifo and dmpg_back
module dual_motor_pulse_generator import dmpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic       motor,
  input  logic [1:0] direction,
  input  logic [6:0] duty,
  input  logic [9:0] high_time,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       enable_a,
  output logic       enable_b,
  output logic       enable_any,
  output logic [1:0] bridge_a,
  output logic [1:0] bridge_b
);

  op_t  wr_op;
  op_t  rd_op;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  dmpg_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .motor     (motor),
    .direction (direction),
    .duty      (duty),
    .high_time (high_time),
    .q_full    (q_full),
    .push      (push),
    .op        (wr_op)
  );

  dmpg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_op (wr_op),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rd_op (rd_op)
  );

  dmpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .op         (rd_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .enable_a   (enable_a),
    .enable_b   (enable_b),
    .enable_any (enable_any),
    .bridge_a   (bridge_a),
    .bridge_b   (bridge_b)
  );

endmodule

>>> dv/dual_motor_pulse_generator_tb.sv
// self-checking testbench for dual_motor_pulse_generator: directed and random ticks and
// drive commands under several idle/stall mixes, results checked against a local predictor
// depends on dmpg_pkg and the pulse generator rtl
`timescale 1ns / 1ps

module dual_motor_pulse_generator_tb import dmpg_pkg::*;;

  localparam int         LIMIT_CYCLES = 400000;
  localparam logic [1:0] DIR_VOID     = 2'd3;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_DRIVE = 1'b1
  } action_t;

  typedef struct packed {
    logic       enable_a;
    logic       enable_b;
    logic       enable_any;
    logic [1:0] bridge_a;
    logic [1:0] bridge_b;
  } pin_state_t;

  class pulse_scoreboard;
    logic [TIME_WIDTH-1:0] count_left [CHANNELS];
    logic [TIME_WIDTH-1:0] hi_live    [CHANNELS];
    logic [TIME_WIDTH-1:0] lo_live    [CHANNELS];
    logic [TIME_WIDTH-1:0] hi_shadow  [CHANNELS];
    logic [TIME_WIDTH-1:0] lo_shadow  [CHANNELS];
    logic                  level_next [CHANNELS];
    logic                  shadow_armed [CHANNELS];
    logic                  halted     [CHANNELS];
    logic                  pin_level  [CHANNELS];
    logic [1:0]            bridge_state [CHANNELS];
    pin_state_t            pending_pins [$];
    int                    mismatches;
    int                    results_seen;
    int                    edge_count;
    int                    restarts;

    function void clear();
      for (int ch = 0; ch < CHANNELS; ch++) begin
        count_left[ch]   = '0;
        level_next[ch]   = 1'b1;
        hi_live[ch]      = RESET_TIME;
        lo_live[ch]      = RESET_TIME;
        shadow_armed[ch] = 1'b0;
        hi_shadow[ch]    = '0;
        lo_shadow[ch]    = '0;
        halted[ch]       = 1'b1;
        pin_level[ch]    = 1'b0;
        bridge_state[ch] = BR_BRAKE;
      end
      pending_pins.delete();
      mismatches   = 0;
      results_seen = 0;
      edge_count   = 0;
      restarts     = 0;
    endfunction

    function int pending();
      return pending_pins.size();
    endfunction

    // low time shrinks with duty; the second channel uses a 9.5 slope, truncated
    function logic [TIME_WIDTH-1:0] low_span(int ch, logic [6:0] duty);
      int d;
      int span;
      d = (duty > DUTY_MAX) ? int'(DUTY_MAX) : int'(duty);
      span = (ch == 0) ? int'(FULL_LOW) - d * 9 : int'(FULL_LOW) - (d * 19) / 2;
      if (span > int'(TIME_MAX)) span = int'(TIME_MAX);
      return TIME_WIDTH'(span);
    endfunction

    function void step_channel(int ch);
      if (halted[ch]) return;
      if (count_left[ch] > 1) begin
        count_left[ch] = count_left[ch] - 1'b1;
        return;
      end
      pin_level[ch]  = level_next[ch];
      count_left[ch] = level_next[ch] ? hi_live[ch] : lo_live[ch];
      level_next[ch] = ~level_next[ch];
      edge_count++;
      if (shadow_armed[ch]) begin
        shadow_armed[ch] = 1'b0;
        hi_live[ch]      = hi_shadow[ch];
        lo_live[ch]      = lo_shadow[ch];
      end
    endfunction

    function void steer_channel(int ch, logic [1:0] dir, logic [6:0] duty,
                                logic [9:0] high);
      logic [TIME_WIDTH-1:0] hi;
      logic [TIME_WIDTH-1:0] lo;
      if (dir == DIR_BRAKE) begin
        bridge_state[ch] = BR_BRAKE;
        if (!halted[ch]) begin
          halted[ch]    = 1'b1;
          pin_level[ch] = 1'b0;
        end
        return;
      end
      bridge_state[ch] = (dir == DIR_FWD) ? BR_FWD : BR_REV;
      hi = (int'(high) > int'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(high);
      lo = low_span(ch, duty);
      if (halted[ch]) begin
        hi_live[ch]    = hi;
        lo_live[ch]    = lo;
        count_left[ch] = hi;
        halted[ch]     = 1'b0;
        restarts++;
      end else begin
        shadow_armed[ch] = 1'b1;
        hi_shadow[ch]    = hi;
        lo_shadow[ch]    = lo;
      end
    endfunction

    function void note_input(action_t act, logic motor, logic [1:0] dir,
                             logic [6:0] duty, logic [9:0] high);
      pin_state_t p;
      if (act == ACT_TICK) begin
        for (int ch = 0; ch < CHANNELS; ch++) step_channel(ch);
      end else if (dir != DIR_VOID && int'(motor) < CHANNELS) begin
        steer_channel(int'(motor), dir, duty, high);
      end
      p.enable_any = 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) p.enable_any = p.enable_any | pin_level[ch];
      p.enable_a = pin_level[0];
      p.enable_b = (CHANNELS > 1) ? pin_level[CH_B] : 1'b0;
      p.bridge_a = bridge_state[0];
      p.bridge_b = (CHANNELS > 1) ? bridge_state[CH_B] : BR_BRAKE;
      pending_pins.push_back(p);
    endfunction

    function void check_result(pin_state_t got);
      pin_state_t want;
      results_seen++;
      if (pending_pins.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
        return;
      end
      want = pending_pins.pop_front();
      if (got.enable_a !== want.enable_a) begin
        $error("enable_a: expected %0d, got %0d", want.enable_a, got.enable_a);
        mismatches++;
      end
      if (got.enable_b !== want.enable_b) begin
        $error("enable_b: expected %0d, got %0d", want.enable_b, got.enable_b);
        mismatches++;
      end
      if (got.enable_any !== want.enable_any) begin
        $error("enable_any: expected %0d, got %0d", want.enable_any, got.enable_any);
        mismatches++;
      end
      if (got.bridge_a !== want.bridge_a) begin
        $error("bridge_a: expected %0d, got %0d", want.bridge_a, got.bridge_a);
        mismatches++;
      end
      if (got.bridge_b !== want.bridge_b) begin
        $error("bridge_b: expected %0d, got %0d", want.bridge_b, got.bridge_b);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = 1'b0;
  logic       motor = 1'b0;
  logic [1:0] direction = 2'd0;
  logic [6:0] duty = 7'd0;
  logic [9:0] high_time = 10'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       enable_a;
  logic       enable_b;
  logic       enable_any;
  logic [1:0] bridge_a;
  logic [1:0] bridge_b;

  pulse_scoreboard sb;
  int send_idle  = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int cycle_count = 0;

  dual_motor_pulse_generator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .motor      (motor),
    .direction  (direction),
    .duty       (duty),
    .high_time  (high_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .enable_a   (enable_a),
    .enable_b   (enable_b),
    .enable_any (enable_any),
    .bridge_a   (bridge_a),
    .bridge_b   (bridge_b)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_input(action_t'(action), motor, direction, duty, high_time);
      end
      if (out_valid && out_ready) begin
        sb.check_result('{enable_a, enable_b, enable_any, bridge_a, bridge_b});
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(action_t a, logic m, logic [1:0] d, logic [6:0] du,
                           logic [9:0] h);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    action    = a;
    motor     = m;
    direction = d;
    duty      = du;
    high_time = h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_item();
    int         pick;
    logic       m;
    logic [1:0] d;
    logic [6:0] du;
    logic [9:0] h;
    pick = $urandom_range(0, 99);
    m    = 1'($urandom_range(0, 1));
    d    = 2'($urandom_range(0, 3));
    du   = 7'($urandom_range(0, 127));
    h    = 10'($urandom_range(0, 1023));
    if (pick < 72) begin
      send_item(ACT_TICK, m, d, du, h);
    end else if (pick < 94) begin
      // short high times and high duty keep the edges coming
      if ($urandom_range(0, 9) < 2) begin
        d = DIR_BRAKE;
      end else begin
        d = $urandom_range(0, 1) ? DIR_FWD : DIR_REV;
      end
      if ($urandom_range(0, 9) < 8) du = 7'($urandom_range(85, 100));
      if ($urandom_range(0, 9) < 9) h = 10'($urandom_range(0, 24));
      send_item(ACT_DRIVE, m, d, du, h);
    end else begin
      send_item(ACT_DRIVE, m, d, du, h);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (count) random_item();
  endtask

  initial begin
    sb = new;
    sb.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opening
    send_item(ACT_TICK,  1'b1, DIR_VOID,  7'd127, 10'd1023);
    send_item(ACT_DRIVE, 1'b0, DIR_BRAKE, 7'd0,   10'd0);
    send_item(ACT_DRIVE, 1'b1, DIR_VOID,  7'd127, 10'd1023);
    send_item(ACT_DRIVE, 1'b0, DIR_FWD,   7'd100, 10'd1);
    send_item(ACT_DRIVE, 1'b1, DIR_REV,   7'd127, 10'd0);
    send_item(ACT_TICK,  1'b0, DIR_BRAKE, 7'd0,   10'd0);
    send_item(ACT_TICK,  1'b1, DIR_REV,   7'd64,  10'd512);
    send_item(ACT_DRIVE, 1'b0, DIR_FWD,   7'd0,   10'd1023);
    send_item(ACT_DRIVE, 1'b1, DIR_FWD,   7'd1,   10'd2);
    send_item(ACT_DRIVE, 1'b0, DIR_BRAKE, 7'd33,  10'd7);
    send_item(ACT_DRIVE, 1'b0, DIR_REV,   7'd50,  10'd3);
    send_item(ACT_TICK,  1'b0, DIR_FWD,   7'd0,   10'd0);
    send_item(ACT_TICK,  1'b0, DIR_FWD,   7'd0,   10'd0);
    send_item(ACT_TICK,  1'b0, DIR_FWD,   7'd0,   10'd0);
    send_item(ACT_TICK,  1'b1, DIR_VOID,  7'd127, 10'd1023);
    send_item(ACT_DRIVE, 1'b1, DIR_BRAKE, 7'd100, 10'd1023);
    send_item(ACT_DRIVE, 1'b1, DIR_BRAKE, 7'd100, 10'd1023);
    send_item(ACT_DRIVE, 1'b1, DIR_FWD,   7'd99,  10'd512);
    send_item(ACT_DRIVE, 1'b0, DIR_VOID,  7'd0,   10'd0);
    send_item(ACT_TICK,  1'b0, DIR_BRAKE, 7'd0,   10'd0);
    wait_drained();

    run_phase(490, 0, 0);
    run_phase(490, 87, 0);
    wait_drained();
    run_phase(490, 0, 87);
    run_phase(490, 6, 6);
    wait_drained();
    recv_stall = 0;
    repeat (8) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, sb.results_seen);
    $display("covered %0d enable edges and %0d channel restarts", sb.edge_count,
             sb.restarts);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
